// ===== design/sbr_pkg.sv =====
// ----------------------------------------------------------------------------
// sbr_pkg: shared types and constants for the signed Barrett reduction block
// Field widths, configuration register indexes, reset values and the sideband
// record that travels with each transaction through the division cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sbr_pkg;

    localparam int VALUE_BITS   = 64;
    localparam int HALF_BITS    = 32;
    localparam int RESIDUE_BITS = 30;
    localparam int FACTOR_BITS  = 64;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_MODULUS = 1'b0,
        CFG_BARRETT = 1'b1
    } cfg_index_t;

    localparam logic [RESIDUE_BITS-1:0] MODULUS_RESET = 30'd3329;
    localparam logic [FACTOR_BITS-1:0]  BARRETT_RESET = 64'd5541226816974932;

    // Per-transaction record carried beside the exact remainder
    typedef struct packed {
        logic                    neg;    // input was negative
        logic                    big;    // magnitude >= modulus * 2^32
        logic                    r_nz;   // Barrett remainder is nonzero
        logic [RESIDUE_BITS-1:0] r_low;  // low bits of the Barrett remainder
    } sbr_side_t;

endpackage

`default_nettype wire

// ===== design/sbr_barrett.sv =====
// ----------------------------------------------------------------------------
// sbr_barrett: magnitude and Barrett estimate pipeline
// Seven stages: capture, magnitude, 32x32 partial products of magnitude times
// factor, quotient estimate, estimate times modulus, remainder, one corrective
// subtract. All stages advance together on en.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_barrett #(
    parameter int W = 30
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              en,
    input  wire                              in_valid,
    input  wire  [sbr_pkg::VALUE_BITS-1:0]   in_value,
    input  wire  [W-1:0]                     q,
    input  wire  [sbr_pkg::FACTOR_BITS-1:0]  mu,
    output logic                             out_valid,
    output logic [sbr_pkg::VALUE_BITS-1:0]   out_mag,
    output sbr_pkg::sbr_side_t               out_side
);
    import sbr_pkg::*;

    localparam int PLO_BITS = HALF_BITS + W;

    // Stage registers
    logic                      p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic                      p5_valid_reg, p6_valid_reg, p7_valid_reg;
    logic [VALUE_BITS-1:0]     p1_raw_reg;
    logic [VALUE_BITS-1:0]     p2_mag_reg, p3_mag_reg, p4_mag_reg, p5_mag_reg;
    logic [VALUE_BITS-1:0]     p6_mag_reg, p7_mag_reg;
    logic                      p2_neg_reg, p3_neg_reg, p4_neg_reg, p5_neg_reg, p6_neg_reg;
    logic                      p3_big_reg, p4_big_reg, p5_big_reg, p6_big_reg;
    logic [VALUE_BITS-1:0]     p3_ll_reg, p3_lh_reg, p3_hl_reg, p3_hh_reg;
    logic [VALUE_BITS-1:0]     p4_est_reg;
    logic [PLO_BITS-1:0]       p5_plo_reg;
    logic [HALF_BITS-1:0]      p5_phi_reg;
    logic [VALUE_BITS-1:0]     p6_r_reg;
    sbr_side_t                 p7_side_reg;

    // Next values
    logic [VALUE_BITS-1:0]     p2_mag_next;
    logic                      p3_big_next;
    logic [VALUE_BITS-1:0]     p3_ll_next, p3_lh_next, p3_hl_next, p3_hh_next;
    logic [HALF_BITS+1:0]      p4_mid;
    logic [VALUE_BITS-1:0]     p4_est_next;
    logic [PLO_BITS-1:0]       p5_plo_next;
    logic [VALUE_BITS-1:0]     p5_phi_full;
    logic [VALUE_BITS-1:0]     p6_r_next;
    logic [VALUE_BITS-1:0]     q_ext;
    logic [VALUE_BITS-1:0]     q_shift;
    logic [VALUE_BITS-1:0]     p7_r;
    sbr_side_t                 p7_side_next;

    assign q_ext   = VALUE_BITS'(q);
    assign q_shift = q_ext << HALF_BITS;

    // Magnitude; the most negative value maps to 2^63
    assign p2_mag_next = p1_raw_reg[VALUE_BITS-1] ? (~p1_raw_reg + 64'd1) : p1_raw_reg;

    // Partial products of magnitude times factor, and the fallback test
    always_comb
    begin
        p3_ll_next  = VALUE_BITS'(p2_mag_reg[HALF_BITS-1:0])
                      * VALUE_BITS'(mu[HALF_BITS-1:0]);
        p3_lh_next  = VALUE_BITS'(p2_mag_reg[HALF_BITS-1:0])
                      * VALUE_BITS'(mu[VALUE_BITS-1:HALF_BITS]);
        p3_hl_next  = VALUE_BITS'(p2_mag_reg[VALUE_BITS-1:HALF_BITS])
                      * VALUE_BITS'(mu[HALF_BITS-1:0]);
        p3_hh_next  = VALUE_BITS'(p2_mag_reg[VALUE_BITS-1:HALF_BITS])
                      * VALUE_BITS'(mu[VALUE_BITS-1:HALF_BITS]);
        p3_big_next = (p2_mag_reg >= q_shift);
    end

    // High half of the 128-bit product: the quotient estimate
    always_comb
    begin
        p4_mid      = (HALF_BITS+2)'(p3_ll_reg[VALUE_BITS-1:HALF_BITS])
                      + (HALF_BITS+2)'(p3_lh_reg[HALF_BITS-1:0])
                      + (HALF_BITS+2)'(p3_hl_reg[HALF_BITS-1:0]);
        p4_est_next = p3_hh_reg
                      + VALUE_BITS'(p3_lh_reg[VALUE_BITS-1:HALF_BITS])
                      + VALUE_BITS'(p3_hl_reg[VALUE_BITS-1:HALF_BITS])
                      + VALUE_BITS'(p4_mid[HALF_BITS+1:HALF_BITS]);
    end

    // Estimate times modulus, split into two narrow products
    always_comb
    begin
        p5_plo_next = PLO_BITS'(p4_est_reg[HALF_BITS-1:0]) * PLO_BITS'(q);
        p5_phi_full = VALUE_BITS'(p4_est_reg[VALUE_BITS-1:HALF_BITS]) * q_ext;
    end

    // Remainder modulo 2^64
    assign p6_r_next = p5_mag_reg - VALUE_BITS'(p5_plo_reg) - (VALUE_BITS'(p5_phi_reg) << HALF_BITS);

    // One corrective subtract
    always_comb
    begin
        p7_r               = (p6_r_reg >= q_ext) ? (p6_r_reg - q_ext) : p6_r_reg;
        p7_side_next.neg   = p6_neg_reg;
        p7_side_next.big   = p6_big_reg;
        p7_side_next.r_nz  = (p7_r != '0);
        p7_side_next.r_low = p7_r[RESIDUE_BITS-1:0];
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
            p7_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
            p6_valid_reg <= p5_valid_reg;
            p7_valid_reg <= p6_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_raw_reg  <= in_value;
            p2_mag_reg  <= p2_mag_next;
            p2_neg_reg  <= p1_raw_reg[VALUE_BITS-1];
            p3_mag_reg  <= p2_mag_reg;
            p3_neg_reg  <= p2_neg_reg;
            p3_big_reg  <= p3_big_next;
            p3_ll_reg   <= p3_ll_next;
            p3_lh_reg   <= p3_lh_next;
            p3_hl_reg   <= p3_hl_next;
            p3_hh_reg   <= p3_hh_next;
            p4_mag_reg  <= p3_mag_reg;
            p4_neg_reg  <= p3_neg_reg;
            p4_big_reg  <= p3_big_reg;
            p4_est_reg  <= p4_est_next;
            p5_mag_reg  <= p4_mag_reg;
            p5_neg_reg  <= p4_neg_reg;
            p5_big_reg  <= p4_big_reg;
            p5_plo_reg  <= p5_plo_next;
            p5_phi_reg  <= p5_phi_full[HALF_BITS-1:0];
            p6_mag_reg  <= p5_mag_reg;
            p6_neg_reg  <= p5_neg_reg;
            p6_big_reg  <= p5_big_reg;
            p6_r_reg    <= p6_r_next;
            p7_mag_reg  <= p6_mag_reg;
            p7_side_reg <= p7_side_next;
        end
    end

    assign out_valid = p7_valid_reg;
    assign out_mag   = p7_mag_reg;
    assign out_side  = p7_side_reg;

endmodule

`default_nettype wire

// ===== design/sbr_div_cell.sv =====
// ----------------------------------------------------------------------------
// sbr_div_cell: one restoring division step
// Shifts the next dividend bit into the partial remainder, subtracts the
// modulus when it fits, and hands the result to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_div_cell #(
    parameter int W = 30
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             en,
    input  wire  [W-1:0]                    q,
    input  wire                             in_valid,
    input  wire  [W-1:0]                    in_rem,
    input  wire  [sbr_pkg::VALUE_BITS-1:0]  in_dvd,
    input  wire  sbr_pkg::sbr_side_t        in_side,
    output logic                            out_valid,
    output logic [W-1:0]                    out_rem,
    output logic [sbr_pkg::VALUE_BITS-1:0]  out_dvd,
    output sbr_pkg::sbr_side_t              out_side
);
    import sbr_pkg::*;

    logic                  valid_reg;
    logic [W-1:0]          rem_reg;
    logic [W-1:0]          rem_next;
    logic [VALUE_BITS-1:0] dvd_reg;
    sbr_side_t             side_reg;
    logic [W:0]            trial;
    logic [W:0]            diff;

    // Shift in one dividend bit and subtract when the modulus fits
    always_comb
    begin
        trial    = {in_rem, in_dvd[VALUE_BITS-1]};
        diff     = trial - {1'b0, q};
        rem_next = (trial >= {1'b0, q}) ? diff[W-1:0] : trial[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            dvd_reg  <= {in_dvd[VALUE_BITS-2:0], 1'b0};
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dvd   = dvd_reg;
    assign out_side  = side_reg;

    // Partial remainder of a live transaction stays below a nonzero modulus
    a_rem_below_q: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (q != '0)) |-> (rem_reg < q))
        else $error("division cell remainder not below modulus");

endmodule

`default_nettype wire

// ===== design/signed_barrett_reduction_top.sv =====
// ----------------------------------------------------------------------------
// signed_barrett_reduction_top: signed 64-bit value reduced modulo q
// Usage:
//   Input channel item_valid/item_stall carries value; a transaction is taken
//   at a clock edge with item_valid high and item_stall low. The result
//   channel result_valid/result_stall carries residue in [0, q).
//   The configuration channel (cfg_valid/cfg_ready, always ready) writes
//   modulus at index 0 and barrett_factor (floor(2^64/q)) at index 1; write
//   only while no transaction is in flight.
// Path: from the accepting edge to result_valid a transaction passes seven Barrett
//   stages, 64 division cells (one quotient bit each) and the output register.
// Throughput: one transaction per cycle while item_stall is low, set by the
//   fully pipelined multiplier stages and the division cell chain.
// Stall: a result held by result_stall waits in the output register while the
//   pipeline keeps running; the next finished result lands in a skid register,
//   and item_stall then rises and the whole pipeline holds until it drains.
// Reset: clears all valid bits and loads q = 3329 and its Barrett factor.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_barrett_reduction_top #(
    parameter int MODULUS_BITS = 30
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // input transactions
    input  wire                                 item_valid,
    output logic                                item_stall,
    input  wire signed [sbr_pkg::VALUE_BITS-1:0] value,
    // result transactions
    output logic                                result_valid,
    input  wire                                 result_stall,
    output logic [sbr_pkg::RESIDUE_BITS-1:0]    residue,
    // configuration writes
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  sbr_pkg::cfg_index_t           cfg_index,
    input  wire  [sbr_pkg::FACTOR_BITS-1:0]     cfg_data
);
    import sbr_pkg::*;

    localparam int W     = MODULUS_BITS;
    localparam int CELLS = VALUE_BITS;

    logic [W-1:0]            modulus_reg;
    logic [FACTOR_BITS-1:0]  barrett_reg;

    logic                    en;
    logic                    accept;

    logic                    bar_valid;
    logic [VALUE_BITS-1:0]   bar_mag;
    sbr_side_t               bar_side;

    logic                    chain_valid [0:CELLS];
    logic [W-1:0]            chain_rem   [0:CELLS];
    logic [VALUE_BITS-1:0]   chain_dvd   [0:CELLS];
    sbr_side_t               chain_side  [0:CELLS];

    logic [RESIDUE_BITS-1:0] q_res;
    logic [RESIDUE_BITS-1:0] sel_r;
    logic                    sel_nz;
    logic [RESIDUE_BITS-1:0] res_next;
    logic                    push;
    logic                    take;

    logic                    result_valid_reg;
    logic [RESIDUE_BITS-1:0] result_reg;
    logic                    skid_valid_reg;
    logic [RESIDUE_BITS-1:0] skid_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= W'(MODULUS_RESET);
            barrett_reg <= BARRETT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MODULUS: modulus_reg <= cfg_data[W-1:0];
                CFG_BARRETT: barrett_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Pipeline runs whenever the skid register is free
    assign en         = !skid_valid_reg;
    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && !item_stall;

    sbr_barrett #(
        .W (W)
    ) u_barrett (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (accept),
        .in_value  (value),
        .q         (modulus_reg),
        .mu        (barrett_reg),
        .out_valid (bar_valid),
        .out_mag   (bar_mag),
        .out_side  (bar_side)
    );

    // Exact remainder: a row of restoring division cells
    assign chain_valid[0] = bar_valid;
    assign chain_rem[0]   = '0;
    assign chain_dvd[0]   = bar_mag;
    assign chain_side[0]  = bar_side;

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        sbr_div_cell #(
            .W (W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .q         (modulus_reg),
            .in_valid  (chain_valid[i]),
            .in_rem    (chain_rem[i]),
            .in_dvd    (chain_dvd[i]),
            .in_side   (chain_side[i]),
            .out_valid (chain_valid[i+1]),
            .out_rem   (chain_rem[i+1]),
            .out_dvd   (chain_dvd[i+1]),
            .out_side  (chain_side[i+1])
        );
    end

    // Pick the path, then map negative inputs
    always_comb
    begin
        q_res  = RESIDUE_BITS'(modulus_reg);
        sel_r  = chain_side[CELLS].big ? RESIDUE_BITS'(chain_rem[CELLS])
                                       : chain_side[CELLS].r_low;
        sel_nz = chain_side[CELLS].big ? (chain_rem[CELLS] != '0)
                                       : chain_side[CELLS].r_nz;
        if (modulus_reg == '0)
        begin
            res_next = '0;
        end
        else if (chain_side[CELLS].neg && sel_nz)
        begin
            res_next = q_res - sel_r;
        end
        else
        begin
            res_next = sel_r;
        end
    end

    // Output register with skid stage
    assign push = en && chain_valid[CELLS];
    assign take = result_valid_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (result_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                result_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                result_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (result_valid_reg && !take)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                result_reg <= res_next;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign residue      = result_reg;

    // A held skid entry always sits behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid holds a transaction while the output is empty");

    // Skid fills only when the output was blocked
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(result_valid_reg && result_stall))
        else $error("skid filled while the output was free");

    // Zero modulus delivers zero
    a_zero_modulus: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (modulus_reg == '0) && !skid_valid_reg
            && $past(push) && !$past(skid_valid_reg)) |-> (residue == '0))
        else $error("nonzero residue for zero modulus");

endmodule

`default_nettype wire
